FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising edge of clk while rst_n is high.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/bgrb_pkg.sv
// ----------------------------------------------------------------------------
// Banked GPIO register block package
// Bank geometry, address decode codes, pad bit positions and the alias helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bgrb_pkg;

  localparam int BANK0_PINS = 28;
  localparam int BANK1_PINS = 6;
  localparam int BANK2_PINS = 20;
  localparam int NUM_BANKS  = 3;
  localparam int NUM_PINS   = BANK0_PINS + BANK1_PINS + BANK2_PINS;
  localparam int PIN_W      = $clog2(NUM_PINS);

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 32;
  localparam int FSEL_W  = 5;
  localparam int PAD_W   = 8;

  localparam logic [PAD_W-1:0] PAD_RESET = 8'h80;
  localparam int PAD_OUTDIS_BIT   = 7;
  localparam int PAD_PULLUP_BIT   = 3;
  localparam int PAD_PULLDOWN_BIT = 2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] REGION_CTRL = 2'd0;
  localparam logic [1:0] REGION_OUT  = 2'd1;
  localparam logic [1:0] REGION_PAD  = 2'd2;
  localparam logic [1:0] REGION_NONE = 2'd3;

  localparam logic [1:0] ALIAS_NONE = 2'd0;
  localparam logic [1:0] ALIAS_XOR  = 2'd1;
  localparam logic [1:0] ALIAS_SET  = 2'd2;
  localparam logic [1:0] ALIAS_CLR  = 2'd3;

  localparam logic [9:0] OREG_LEVEL  = 10'd0;
  localparam logic [9:0] OREG_ENABLE = 10'd1;
  localparam logic [9:0] OREG_IN     = 10'd2;

  function automatic int bank_pins(input int b);
    return (b == 0) ? BANK0_PINS : ((b == 1) ? BANK1_PINS : BANK2_PINS);
  endfunction

  function automatic int bank_base(input int b);
    return (b == 0) ? 0 : ((b == 1) ? BANK0_PINS : BANK0_PINS + BANK1_PINS);
  endfunction

  function automatic logic [DATA_W-1:0] alias_apply(input logic [DATA_W-1:0] cur,
                                                    input logic [DATA_W-1:0] data,
                                                    input logic [1:0]        kind);
    logic [DATA_W-1:0] res;
    case (kind)
      ALIAS_NONE: res = data;
      ALIAS_XOR:  res = cur ^ data;
      ALIAS_SET:  res = cur | data;
      default:    res = cur & ~data;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/banked_gpio_register_block.sv
// ----------------------------------------------------------------------------
// Banked GPIO register block
// Three-bank GPIO register file with function select, output, alias and pad
// registers; one bus read or write per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  input   | in_op in_word_address in_write_data ... | start & !busy
//  result  | out_read_data out_*_mask                | out_valid, one cycle
//
//  From start to out_valid a transaction passes the input register, then
//  decode/update with the result register and the function select memory
//  read port.  One transaction per cycle sustained; busy is always low.
//  Masks reflect the state after the transaction.
//  Synchronous active-low reset restores the state registers but not fsel_mem.
//  The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_gpio_register_block (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [bgrb_pkg::ADDR_W-1:0]         in_word_address,
  input  logic [bgrb_pkg::DATA_W-1:0]         in_write_data,
  input  logic [bgrb_pkg::NUM_PINS-1:0]       in_pin_levels,
  output logic                                out_valid,
  output logic [bgrb_pkg::DATA_W-1:0]         out_read_data,
  output logic [bgrb_pkg::NUM_PINS-1:0]       out_drive_enable_mask,
  output logic [bgrb_pkg::NUM_PINS-1:0]       out_drive_level_mask,
  output logic [bgrb_pkg::NUM_PINS-1:0]       out_pull_up_mask,
  output logic [bgrb_pkg::NUM_PINS-1:0]       out_pull_down_mask
);

  `include "assert_macros.svh"

  localparam int NP = bgrb_pkg::NUM_PINS;
  localparam int DW = bgrb_pkg::DATA_W;
  localparam int PW = bgrb_pkg::PIN_W;
  localparam int NB = bgrb_pkg::NUM_BANKS;

  // input register
  logic                          in_fire;
  logic                          vld_r;
  logic                          op_r;
  logic [bgrb_pkg::ADDR_W-1:0]   addr_r;
  logic [DW-1:0]                 data_r;
  logic [NP-1:0]                 lvl_r;

  // state
  logic [bgrb_pkg::FSEL_W-1:0]   fsel_mem [NP];
  logic [NP-1:0]                 fsel_vld_r;
  logic [bgrb_pkg::PAD_W-1:0][NP-1:0] pad_r;
  logic [DW-1:0]                 volt_r [NB];
  logic [NP-1:0]                 out_lvl_r;
  logic [NP-1:0]                 out_en_r;
  logic [NP-1:0]                 out_lvl_nxt;
  logic [NP-1:0]                 out_en_nxt;

  // result register
  logic                          out_vld_r;
  logic [DW-1:0]                 rd_r;
  logic [DW-1:0]                 rd_nxt;
  logic                          fsel_sel_r;
  logic [bgrb_pkg::FSEL_W-1:0]   fsel_q_r;

  // decode
  logic [1:0]                    region;
  logic [1:0]                    bank;
  logic [11:0]                   woff;
  logic [11:0]                   woff_m1;
  logic [1:0]                    akind;
  logic [9:0]                    oreg;
  logic                          hit;
  logic [PW-1:0]                 base;
  logic [11:0]                   npins;
  logic                          ctl_ok;
  logic                          pad_ok;
  logic                          volt_ok;
  logic                          op_wr;
  logic                          wr;
  logic                          rd;
  logic [PW-1:0]                 fsel_idx;
  logic [PW-1:0]                 pad_idx;
  logic [DW-1:0]                 bank_lvl [NB];
  logic [DW-1:0]                 bank_en  [NB];
  logic [DW-1:0]                 bank_in  [NB];
  logic [DW-1:0]                 pad_rd;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_fire;
    end
    if (in_fire) begin
      op_r   <= in_op;
      addr_r <= in_word_address;
      data_r <= in_write_data;
      lvl_r  <= in_pin_levels;
    end
  end

  assign region  = addr_r[15:14];
  assign bank    = addr_r[13:12];
  assign woff    = addr_r[11:0];
  assign woff_m1 = woff - 12'd1;
  assign akind   = woff[11:10];
  assign oreg    = woff[9:0];
  assign hit     = vld_r && (region != bgrb_pkg::REGION_NONE) && (bank != 2'd3);
  assign op_wr   = (op_r == bgrb_pkg::OP_WRITE);
  assign wr      = hit && op_wr;
  assign rd      = hit && (op_r == bgrb_pkg::OP_READ);

  always_comb begin
    unique case (bank)
      2'd0:    begin
        base  = PW'(bgrb_pkg::bank_base(0));
        npins = 12'(bgrb_pkg::bank_pins(0));
      end
      2'd1:    begin
        base  = PW'(bgrb_pkg::bank_base(1));
        npins = 12'(bgrb_pkg::bank_pins(1));
      end
      default: begin
        base  = PW'(bgrb_pkg::bank_base(2));
        npins = 12'(bgrb_pkg::bank_pins(2));
      end
    endcase
  end

  assign ctl_ok   = (region == bgrb_pkg::REGION_CTRL) && woff[0] && ({1'b0, woff[11:1]} < npins);
  assign volt_ok  = (region == bgrb_pkg::REGION_PAD) && (woff == 12'd0);
  assign pad_ok   = (region == bgrb_pkg::REGION_PAD) && (woff != 12'd0) && (woff_m1 < npins);
  assign fsel_idx = base + woff[PW:1];
  assign pad_idx  = base + woff_m1[PW-1:0];

  // per-bank views and next values of the output registers
  for (genvar b = 0; b < NB; b++) begin : g_bank
    localparam int BB = bgrb_pkg::bank_base(b);
    localparam int BN = bgrb_pkg::bank_pins(b);
    logic bsel;

    assign bsel        = wr && (region == bgrb_pkg::REGION_OUT) && (bank == 2'(b));
    assign bank_lvl[b] = DW'(out_lvl_r[BB +: BN]);
    assign bank_en[b]  = DW'(out_en_r[BB +: BN]);
    assign bank_in[b]  = DW'(lvl_r[BB +: BN]);

    assign out_lvl_nxt[BB +: BN] = (bsel && (oreg == bgrb_pkg::OREG_LEVEL))
      ? BN'(bgrb_pkg::alias_apply(bank_lvl[b], data_r, akind)) : out_lvl_r[BB +: BN];
    assign out_en_nxt[BB +: BN]  = (bsel && (oreg == bgrb_pkg::OREG_ENABLE))
      ? BN'(bgrb_pkg::alias_apply(bank_en[b], data_r, akind)) : out_en_r[BB +: BN];
  end

  always_comb begin
    for (int k = 0; k < bgrb_pkg::PAD_W; k++) begin
      pad_rd[k] = pad_r[k][pad_idx];
    end
    pad_rd[DW-1:bgrb_pkg::PAD_W] = '0;
  end

  always_comb begin
    rd_nxt = '0;
    if (rd) begin
      unique case (region)
        bgrb_pkg::REGION_OUT: begin
          if (akind == bgrb_pkg::ALIAS_NONE) begin
            if (oreg == bgrb_pkg::OREG_LEVEL) begin
              rd_nxt = bank_lvl[bank];
            end else if (oreg == bgrb_pkg::OREG_ENABLE) begin
              rd_nxt = bank_en[bank];
            end else if (oreg == bgrb_pkg::OREG_IN) begin
              rd_nxt = bank_in[bank];
            end
          end
        end
        bgrb_pkg::REGION_PAD: begin
          if (volt_ok) begin
            rd_nxt = volt_r[bank];
          end else if (pad_ok) begin
            rd_nxt = pad_rd;
          end
        end
        default: rd_nxt = '0;
      endcase
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_vld_r <= '0;
      for (int k = 0; k < bgrb_pkg::PAD_W; k++) begin
        pad_r[k] <= {NP{bgrb_pkg::PAD_RESET[k]}};
      end
      for (int b = 0; b < NB; b++) begin
        volt_r[b] <= '0;
      end
      out_lvl_r  <= '0;
      out_en_r   <= '0;
    end else begin
      out_lvl_r <= out_lvl_nxt;
      out_en_r  <= out_en_nxt;
      if (wr && ctl_ok) begin
        fsel_vld_r[fsel_idx] <= 1'b1;
      end
      if (wr && volt_ok) begin
        volt_r[bank] <= data_r;
      end
      if (wr && pad_ok) begin
        for (int k = 0; k < bgrb_pkg::PAD_W; k++) begin
          pad_r[k][pad_idx] <= data_r[k];
        end
      end
    end
  end

  // function select memory
  always_ff @(posedge clk) begin
    if (wr && ctl_ok) begin
      fsel_mem[fsel_idx] <= data_r[bgrb_pkg::FSEL_W-1:0];
    end
    if (rd && ctl_ok) begin
      fsel_q_r <= fsel_mem[fsel_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      fsel_sel_r <= 1'b0;
    end else begin
      out_vld_r  <= vld_r;
      fsel_sel_r <= rd && ctl_ok && fsel_vld_r[fsel_idx];
    end
    rd_r <= rd_nxt;
  end

  assign out_valid             = out_vld_r;
  assign out_read_data         = fsel_sel_r ? DW'(fsel_q_r) : rd_r;
  assign out_drive_enable_mask = out_en_r & ~pad_r[bgrb_pkg::PAD_OUTDIS_BIT];
  assign out_drive_level_mask  = out_lvl_r;
  assign out_pull_up_mask      = pad_r[bgrb_pkg::PAD_PULLUP_BIT];
  assign out_pull_down_mask    = pad_r[bgrb_pkg::PAD_PULLDOWN_BIT];

  `ASSERT_IMP(a_result_follows, $past(in_fire, 2) && $past(rst_n), out_valid, "transaction lost")
  `ASSERT_IMP(a_no_extra_result, out_valid, $past(in_fire, 2), "result without transaction")
  `ASSERT_IMP(a_write_reads_zero, out_valid && $past(op_wr), out_read_data == '0, "write data")
  `ASSERT_CLK(a_fsel_vld_sticky, ($past(fsel_vld_r) & ~fsel_vld_r) == '0, "valid bit cleared")

endmodule

`default_nettype wire

FILE: tb/tb_banked_gpio_register_block.sv
// ----------------------------------------------------------------------------
// Banked GPIO register block testbench
// Drives bus reads and writes over all three register regions, with random
// idle bursts, and predicts the read data and pin masks of every transaction.
// Each strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_banked_gpio_register_block;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ACCESSES = 925;

  typedef struct {
    logic                          op;
    logic [bgrb_pkg::ADDR_W-1:0]   addr;
    logic [bgrb_pkg::DATA_W-1:0]   data;
    logic [bgrb_pkg::NUM_PINS-1:0] levels;
  } bus_access_t;

  typedef struct {
    logic [bgrb_pkg::DATA_W-1:0]   rdata;
    logic [bgrb_pkg::NUM_PINS-1:0] drive_en;
    logic [bgrb_pkg::NUM_PINS-1:0] drive_lvl;
    logic [bgrb_pkg::NUM_PINS-1:0] pull_up;
    logic [bgrb_pkg::NUM_PINS-1:0] pull_dn;
  } pin_view_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_op = 1'b0;
  logic [bgrb_pkg::ADDR_W-1:0]   in_word_address = '0;
  logic [bgrb_pkg::DATA_W-1:0]   in_write_data = '0;
  logic [bgrb_pkg::NUM_PINS-1:0] in_pin_levels = '0;
  logic                          out_valid;
  logic [bgrb_pkg::DATA_W-1:0]   out_read_data;
  logic [bgrb_pkg::NUM_PINS-1:0] out_drive_enable_mask;
  logic [bgrb_pkg::NUM_PINS-1:0] out_drive_level_mask;
  logic [bgrb_pkg::NUM_PINS-1:0] out_pull_up_mask;
  logic [bgrb_pkg::NUM_PINS-1:0] out_pull_down_mask;

  bus_access_t pending_access[$];
  pin_view_t   expected_view[$];
  bus_access_t on_bus;

  logic [bgrb_pkg::FSEL_W-1:0] fsel_shadow [bgrb_pkg::NUM_PINS];
  logic [bgrb_pkg::PAD_W-1:0]  pad_shadow [bgrb_pkg::NUM_PINS];
  logic [bgrb_pkg::DATA_W-1:0] volt_shadow [bgrb_pkg::NUM_BANKS];
  logic [bgrb_pkg::DATA_W-1:0] level_shadow [bgrb_pkg::NUM_BANKS];
  logic [bgrb_pkg::DATA_W-1:0] oe_shadow [bgrb_pkg::NUM_BANKS];
  int                          bank_n [bgrb_pkg::NUM_BANKS];
  int                          bank_lo [bgrb_pkg::NUM_BANKS];

  int gap_left = 0;
  int n_accepted = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycles = 0;

  always #6 clk = ~clk;

  banked_gpio_register_block u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_op                 (in_op),
    .in_word_address       (in_word_address),
    .in_write_data         (in_write_data),
    .in_pin_levels         (in_pin_levels),
    .out_valid             (out_valid),
    .out_read_data         (out_read_data),
    .out_drive_enable_mask (out_drive_enable_mask),
    .out_drive_level_mask  (out_drive_level_mask),
    .out_pull_up_mask      (out_pull_up_mask),
    .out_pull_down_mask    (out_pull_down_mask)
  );

  function automatic logic [bgrb_pkg::ADDR_W-1:0] reg_word(input logic [1:0] region,
                                                           input int bank, input int w);
    return {region, 2'(bank), 12'(w)};
  endfunction

  function automatic logic [bgrb_pkg::ADDR_W-1:0] out_reg(input int bank,
                                                          input logic [1:0] kind,
                                                          input logic [9:0] oreg);
    return {bgrb_pkg::REGION_OUT, 2'(bank), kind, oreg};
  endfunction

  function automatic logic [bgrb_pkg::DATA_W-1:0] aliased_write(
      input logic [bgrb_pkg::DATA_W-1:0] cur,
      input logic [bgrb_pkg::DATA_W-1:0] data,
      input logic [1:0]                  kind,
      input logic [bgrb_pkg::DATA_W-1:0] keep);
    logic [bgrb_pkg::DATA_W-1:0] nv;
    case (kind)
      bgrb_pkg::ALIAS_XOR: nv = cur ^ data;
      bgrb_pkg::ALIAS_SET: nv = cur | data;
      bgrb_pkg::ALIAS_CLR: nv = cur & ~data;
      default:             nv = data;
    endcase
    return nv & keep;
  endfunction

  // Updates the shadow registers and returns read data plus the pin masks.
  function automatic pin_view_t apply_bus_access(input bus_access_t a);
    pin_view_t                   v;
    logic [1:0]                  region;
    logic [1:0]                  kind;
    logic [bgrb_pkg::DATA_W-1:0] keep;
    int                          bank, n, base, w, r, pin, j;
    v.rdata = '0;
    v.drive_en = '0;
    v.drive_lvl = '0;
    v.pull_up = '0;
    v.pull_dn = '0;
    region = a.addr[15:14];
    bank = int'(a.addr[13:12]);
    w = int'(a.addr[11:0]);
    kind = a.addr[11:10];
    r = int'(a.addr[9:0]);
    if (region != bgrb_pkg::REGION_NONE && bank < bgrb_pkg::NUM_BANKS) begin
      n = bank_n[bank];
      base = bank_lo[bank];
      keep = {bgrb_pkg::DATA_W{1'b1}} >> (bgrb_pkg::DATA_W - n);
      case (region)
        bgrb_pkg::REGION_CTRL: begin
          if (a.addr[0] && (w >> 1) < n) begin
            if (a.op == bgrb_pkg::OP_WRITE) begin
              fsel_shadow[base + (w >> 1)] = a.data[bgrb_pkg::FSEL_W-1:0];
            end else begin
              v.rdata = bgrb_pkg::DATA_W'(fsel_shadow[base + (w >> 1)]);
            end
          end
        end
        bgrb_pkg::REGION_OUT: begin
          if (a.op == bgrb_pkg::OP_WRITE) begin
            if (r == bgrb_pkg::OREG_LEVEL)
              level_shadow[bank] = aliased_write(level_shadow[bank], a.data, kind, keep);
            else if (r == bgrb_pkg::OREG_ENABLE)
              oe_shadow[bank] = aliased_write(oe_shadow[bank], a.data, kind, keep);
          end else if (kind == bgrb_pkg::ALIAS_NONE) begin
            if (r == bgrb_pkg::OREG_LEVEL) v.rdata = level_shadow[bank];
            else if (r == bgrb_pkg::OREG_ENABLE) v.rdata = oe_shadow[bank];
            else if (r == bgrb_pkg::OREG_IN)
              for (j = 0; j < n; j++) v.rdata[j] = a.levels[base + j];
          end
        end
        default: begin
          if (w == 0) begin
            if (a.op == bgrb_pkg::OP_WRITE) volt_shadow[bank] = a.data;
            else v.rdata = volt_shadow[bank];
          end else if (w - 1 < n) begin
            if (a.op == bgrb_pkg::OP_WRITE) begin
              pad_shadow[base + w - 1] = a.data[bgrb_pkg::PAD_W-1:0];
            end else begin
              v.rdata = bgrb_pkg::DATA_W'(pad_shadow[base + w - 1]);
            end
          end
        end
      endcase
    end
    for (bank = 0; bank < bgrb_pkg::NUM_BANKS; bank++) begin
      for (j = 0; j < bank_n[bank]; j++) begin
        pin = bank_lo[bank] + j;
        v.drive_en[pin]  = oe_shadow[bank][j] & ~pad_shadow[pin][bgrb_pkg::PAD_OUTDIS_BIT];
        v.drive_lvl[pin] = level_shadow[bank][j];
        v.pull_up[pin]   = pad_shadow[pin][bgrb_pkg::PAD_PULLUP_BIT];
        v.pull_dn[pin]   = pad_shadow[pin][bgrb_pkg::PAD_PULLDOWN_BIT];
      end
    end
    return v;
  endfunction

  // Mostly mapped registers with random content; the rest is unmapped noise.
  function automatic bus_access_t random_access();
    bus_access_t a;
    logic [63:0] lv;
    logic [31:0] rnd;
    int          sel, bank, n;
    sel = int'($urandom_range(0, 99));
    bank = int'($urandom_range(0, bgrb_pkg::NUM_BANKS - 1));
    n = bank_n[bank];
    lv = {$urandom, $urandom};
    rnd = $urandom;
    a.op = 1'($urandom_range(0, 1));
    a.data = $urandom;
    a.levels = lv[bgrb_pkg::NUM_PINS-1:0];
    if (sel < 25) begin
      a.addr = reg_word(bgrb_pkg::REGION_CTRL, bank, 2 * int'($urandom_range(0, n - 1)) + 1);
    end else if (sel < 30) begin
      a.addr = reg_word(bgrb_pkg::REGION_CTRL, bank, 2 * int'($urandom_range(0, n - 1)));
    end else if (sel < 60) begin
      a.addr = out_reg(bank, 2'($urandom_range(0, 3)), 10'($urandom_range(0, 2)));
    end else if (sel < 85) begin
      a.addr = reg_word(bgrb_pkg::REGION_PAD, bank, int'($urandom_range(0, n)));
    end else begin
      case ($urandom_range(0, 3))
        0: a.addr = rnd[bgrb_pkg::ADDR_W-1:0];
        1: a.addr = reg_word(2'($urandom_range(0, 2)), 3, int'($urandom_range(0, 4095)));
        2: a.addr = $urandom_range(0, 1) ?
                    reg_word(bgrb_pkg::REGION_CTRL, bank, int'($urandom_range(2 * n, 4095))) :
                    reg_word(bgrb_pkg::REGION_PAD, bank, int'($urandom_range(n + 1, 4095)));
        default: a.addr = out_reg(bank, 2'($urandom_range(0, 3)),
                                  10'($urandom_range(3, 1023)));
      endcase
    end
    return a;
  endfunction

  task automatic push_access(input logic op, input logic [bgrb_pkg::ADDR_W-1:0] addr,
                             input logic [bgrb_pkg::DATA_W-1:0] data,
                             input logic [bgrb_pkg::NUM_PINS-1:0] levels);
    bus_access_t a;
    a.op = op;
    a.addr = addr;
    a.data = data;
    a.levels = levels;
    pending_access.push_back(a);
  endtask

  task automatic drive_ports(input bus_access_t a);
    in_op <= a.op;
    in_word_address <= a.addr;
    in_write_data <= a.data;
    in_pin_levels <= a.levels;
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_view.push_back(apply_bus_access(on_bus));
        n_accepted++;
        if (on_bus.op == bgrb_pkg::OP_WRITE) n_writes++;
      end
      if (start && busy) begin
        // hold the transaction
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        drive_ports(random_access());
      end else if (pending_access.size() > 150 && $urandom_range(0, 11) == 0) begin
        gap_left = int'($urandom_range(0, 10));
        start <= 1'b0;
        drive_ports(random_access());
      end else if (pending_access.size() != 0) begin
        on_bus = pending_access.pop_front();
        start <= 1'b1;
        drive_ports(on_bus);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    pin_view_t want;
    if (rst_n && out_valid) begin
      if (expected_view.size() == 0) begin
        $display("%0t: result with no transaction pending, read data %h", $time,
                 out_read_data);
        n_errors++;
      end else begin
        want = expected_view.pop_front();
        n_checked++;
        check_field("read_data", 64'(want.rdata), 64'(out_read_data));
        check_field("drive_enable_mask", 64'(want.drive_en), 64'(out_drive_enable_mask));
        check_field("drive_level_mask", 64'(want.drive_lvl), 64'(out_drive_level_mask));
        check_field("pull_up_mask", 64'(want.pull_up), 64'(out_pull_up_mask));
        check_field("pull_down_mask", 64'(want.pull_dn), 64'(out_pull_down_mask));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_view.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [bgrb_pkg::NUM_PINS-1:0] ones;
    ones = '1;
    bank_n[0] = bgrb_pkg::BANK0_PINS;
    bank_n[1] = bgrb_pkg::BANK1_PINS;
    bank_n[2] = bgrb_pkg::BANK2_PINS;
    bank_lo[0] = 0;
    bank_lo[1] = bgrb_pkg::BANK0_PINS;
    bank_lo[2] = bgrb_pkg::BANK0_PINS + bgrb_pkg::BANK1_PINS;
    for (int i = 0; i < bgrb_pkg::NUM_PINS; i++) begin
      fsel_shadow[i] = '0;
      pad_shadow[i] = bgrb_pkg::PAD_RESET;
    end
    for (int b = 0; b < bgrb_pkg::NUM_BANKS; b++) begin
      volt_shadow[b] = '0;
      level_shadow[b] = '0;
      oe_shadow[b] = '0;
    end

    push_access(bgrb_pkg::OP_READ,  reg_word(bgrb_pkg::REGION_CTRL, 0, 1), '1, '0);
    push_access(bgrb_pkg::OP_WRITE, reg_word(bgrb_pkg::REGION_CTRL, 0, 1), '1, '0);
    push_access(bgrb_pkg::OP_READ,  reg_word(bgrb_pkg::REGION_CTRL, 0, 1), '0, ones);
    push_access(bgrb_pkg::OP_WRITE,
                reg_word(bgrb_pkg::REGION_CTRL, 2, 2 * bgrb_pkg::BANK2_PINS - 1), 32'h15, '0);
    push_access(bgrb_pkg::OP_WRITE, reg_word(bgrb_pkg::REGION_CTRL, 1, 0), '1, '0);
    push_access(bgrb_pkg::OP_READ,  reg_word(bgrb_pkg::REGION_CTRL, 1, 0), '0, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(0, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_LEVEL), '1, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(0, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_ENABLE), '1, '0);
    push_access(bgrb_pkg::OP_READ,
                out_reg(0, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_LEVEL), '0, '0);
    push_access(bgrb_pkg::OP_READ,
                out_reg(0, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_ENABLE), '0, '0);
    push_access(bgrb_pkg::OP_WRITE, reg_word(bgrb_pkg::REGION_PAD, 0, 1), 32'h4c, '0);
    push_access(bgrb_pkg::OP_WRITE,
                reg_word(bgrb_pkg::REGION_PAD, 2, bgrb_pkg::BANK2_PINS), 32'hffff_ff08, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(1, bgrb_pkg::ALIAS_XOR, bgrb_pkg::OREG_LEVEL), 32'h2a, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(1, bgrb_pkg::ALIAS_SET, bgrb_pkg::OREG_ENABLE), '1, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(0, bgrb_pkg::ALIAS_CLR, bgrb_pkg::OREG_LEVEL), 32'h0f0f0f0f, '0);
    push_access(bgrb_pkg::OP_READ,
                out_reg(0, bgrb_pkg::ALIAS_XOR, bgrb_pkg::OREG_LEVEL), '0, '0);
    push_access(bgrb_pkg::OP_WRITE,
                out_reg(2, bgrb_pkg::ALIAS_SET, bgrb_pkg::OREG_IN), '1, ones);
    push_access(bgrb_pkg::OP_READ,
                out_reg(0, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_IN), '0, ones);
    push_access(bgrb_pkg::OP_READ,
                out_reg(1, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_IN), '0,
                54'h2a_aaaa_aaaa_aaaa);
    push_access(bgrb_pkg::OP_READ,
                out_reg(2, bgrb_pkg::ALIAS_NONE, bgrb_pkg::OREG_IN), '0, ones);
    push_access(bgrb_pkg::OP_WRITE, reg_word(bgrb_pkg::REGION_PAD, 2, 0), '1, '0);
    push_access(bgrb_pkg::OP_READ,  reg_word(bgrb_pkg::REGION_PAD, 2, 0), '0, '0);
    push_access(bgrb_pkg::OP_WRITE,
                reg_word(bgrb_pkg::REGION_PAD, 1, bgrb_pkg::BANK1_PINS + 1), 32'h0c, '0);
    push_access(bgrb_pkg::OP_READ,
                reg_word(bgrb_pkg::REGION_PAD, 1, bgrb_pkg::BANK1_PINS), '0, '0);
    push_access(bgrb_pkg::OP_WRITE, reg_word(bgrb_pkg::REGION_PAD, 3, 1), 32'h0c, '0);
    push_access(bgrb_pkg::OP_READ,  16'hffff, '1, ones);
    for (int i = 0; i < RANDOM_ACCESSES; i++) pending_access.push_back(random_access());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_access.size() != 0 || start || expected_view.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bus transactions (%0d writes, %0d reads), %0d results compared",
             n_accepted, n_writes, n_accepted - n_writes, n_checked);
    $display("covered function select, out/oe/in with xor/set/clear aliases, pads, unmapped");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
